>>> design/lbm_pkg.sv
// Shared types, constants and a decode function of the lamp blink mode controller.
`default_nettype none

package lbm_pkg;

   localparam int NUM_SLOTS_DEF = 16;
   localparam int MASK_BITS_DEF = 32;

   localparam int LAMP_W    = 32;
   localparam int IDX_W     = 4;
   localparam int MODE_W    = 3;
   localparam int TICKS_W   = 8;
   localparam int PHASE_W   = 9;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 8;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_WRITE_SLOT,
      CMD_SET_MODE,
      CMD_READ_MODE
   } cmd_type;

   localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_STEADY  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FLASH   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FLUTTER = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BROKEN  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_WINK    = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_LAMP_INDEX    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FLASH_ON_TICKS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FLASH_OFF_TICKS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FLUTTER_ON_TICKS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FLUTTER_OFF_TICKS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WINK_ON_TICKS     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WINK_OFF_TICKS    = 3'd6;

   localparam logic [IDX_W-1:0]   MAX_LAMP_INDEX_RST    = 4'd15;
   localparam logic [TICKS_W-1:0] FLASH_ON_TICKS_RST    = 8'd4;
   localparam logic [TICKS_W-1:0] FLASH_OFF_TICKS_RST   = 8'd4;
   localparam logic [TICKS_W-1:0] FLUTTER_ON_TICKS_RST  = 8'd1;
   localparam logic [TICKS_W-1:0] FLUTTER_OFF_TICKS_RST = 8'd1;
   localparam logic [TICKS_W-1:0] WINK_ON_TICKS_RST     = 8'd7;
   localparam logic [TICKS_W-1:0] WINK_OFF_TICKS_RST    = 8'd1;

   typedef struct packed {
      logic capture;
      logic phase_step;
      logic scan_issue;
      logic scan_take;
      logic commit;
   } ctl_type;

   function automatic logic mode_lit(input logic [MODE_W-1:0] mode, input logic flash,
                                     input logic flutter, input logic wink);
      logic lit;
      unique case (mode)
         MODE_STEADY:  lit = 1'b1;
         MODE_FLASH:   lit = flash;
         MODE_FLUTTER: lit = flutter;
         MODE_BROKEN:  lit = flash & flutter;
         MODE_WINK:    lit = wink;
         default:      lit = 1'b0;
      endcase
      return lit;
   endfunction

endpackage

`default_nettype wire

>>> design/lbm_req_if.sv
// Request channel interface of the lamp blink mode controller.
`default_nettype none

interface lbm_req_if;
   import lbm_pkg::*;

   logic                valid;
   logic                ready;
   cmd_type             command;
   logic [IDX_W-1:0]    slot_index;
   logic [LAMP_W-1:0]   lamp_mask;
   logic [MODE_W-1:0]   lamp_mode;

   modport source (output valid, command, slot_index, lamp_mask, lamp_mode, input ready);
   modport sink   (input valid, command, slot_index, lamp_mask, lamp_mode, output ready);
endinterface

`default_nettype wire

>>> design/lbm_rsp_if.sv
// Response channel interface of the lamp blink mode controller.
`default_nettype none

interface lbm_rsp_if;
   import lbm_pkg::*;

   logic                valid;
   logic                ready;
   logic [LAMP_W-1:0]   lamps_on;
   logic                lamps_changed;
   logic                status;
   logic [MODE_W-1:0]   mode_read;

   modport source (output valid, lamps_on, lamps_changed, status, mode_read, input ready);
   modport sink   (input valid, lamps_on, lamps_changed, status, mode_read, output ready);
endinterface

`default_nettype wire

>>> design/lbm_csr_if.sv
// Register write channel interface of the lamp blink mode controller.
`default_nettype none

interface lbm_csr_if;
   import lbm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DAT_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/lbm_ctrl.sv
// Sequencing state machine of the lamp blink mode controller.
`default_nettype none

module lbm_ctrl #(
   parameter int NUM_SLOTS = lbm_pkg::NUM_SLOTS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   input  wire lbm_pkg::cmd_type                        req_command,
   output logic                                         req_ready,
   input  wire logic                                    rsp_ready,
   output logic                                         rsp_valid,
   input  wire logic [$clog2(NUM_SLOTS+1)-1:0]          slot_count,
   output lbm_pkg::ctl_type                             ctl,
   output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] scan_addr
);
   import lbm_pkg::*;

   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PHASE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pend_in   = pend_ff;
      ctl       = '0;
      req_ready = (state_ff == S_IDLE);
      out_free  = !rsp_valid_ff || rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               cnt_in      = '0;
               pend_in     = 1'b0;
               unique case (req_command) inside
                  CMD_TICK:                    state_in = S_PHASE;
                  CMD_WRITE_SLOT:              state_in = S_DONE;
                  CMD_SET_MODE, CMD_READ_MODE: state_in = S_SCAN;
               endcase
            end
         end
         S_PHASE: begin
            ctl.phase_step = 1'b1;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            ctl.scan_issue = (cnt_ff < slot_count);
            ctl.scan_take  = pend_ff;
            pend_in        = ctl.scan_issue;
            if (ctl.scan_issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               ctl.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
      endcase
      rsp_valid_in = ctl.commit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign scan_addr = cnt_ff[SLOT_W-1:0];

endmodule

`default_nettype wire

>>> design/lbm_datapath.sv
// Slot table, pattern phases, registers and response register of the lamp controller.
`default_nettype none

module lbm_datapath #(
   parameter int NUM_SLOTS = lbm_pkg::NUM_SLOTS_DEF,
   parameter int MASK_BITS = lbm_pkg::MASK_BITS_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire lbm_pkg::ctl_type                          ctl,
   input  wire logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] scan_addr,
   output logic [$clog2(NUM_SLOTS+1)-1:0]                 slot_count,
   input  wire lbm_pkg::cmd_type                          req_command,
   input  wire logic [lbm_pkg::IDX_W-1:0]                 req_slot_index,
   input  wire logic [lbm_pkg::LAMP_W-1:0]                req_lamp_mask,
   input  wire logic [lbm_pkg::MODE_W-1:0]                req_lamp_mode,
   input  wire logic                                      csr_write,
   input  wire logic [lbm_pkg::CSR_IDX_W-1:0]             csr_index,
   input  wire logic [lbm_pkg::CSR_DAT_W-1:0]             csr_data,
   output logic [lbm_pkg::LAMP_W-1:0]                     rsp_lamps_on,
   output logic                                           rsp_lamps_changed,
   output logic                                           rsp_status,
   output logic [lbm_pkg::MODE_W-1:0]                     rsp_mode_read
);
   import lbm_pkg::*;

   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SW     = (MASK_BITS < LAMP_W) ? MASK_BITS : LAMP_W;

   function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] ph,
                                                    input logic [TICKS_W-1:0] on_t,
                                                    input logic [TICKS_W-1:0] off_t);
      logic [PHASE_W-1:0] inc;
      logic [PHASE_W-1:0] period;
      inc    = ph + PHASE_W'(1);
      period = PHASE_W'(on_t) + PHASE_W'(off_t);
      return (inc >= period) ? '0 : inc;
   endfunction

   logic [IDX_W-1:0]   max_lamp_ff;
   logic [TICKS_W-1:0] flash_on_ff, flash_off_ff;
   logic [TICKS_W-1:0] flutter_on_ff, flutter_off_ff;
   logic [TICKS_W-1:0] wink_on_ff, wink_off_ff;

   logic [PHASE_W-1:0] flash_ph_ff, flutter_ph_ff, wink_ph_ff;
   logic               flash_lit, flutter_lit, wink_lit;

   cmd_type            cmd_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [SW-1:0]      mask_ff;
   logic [MODE_W-1:0]  mode_ff;

   logic [SW-1:0]      mask_mem [NUM_SLOTS];
   logic [MODE_W-1:0]  mode_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] mask_vld_ff, mode_vld_ff;

   logic [SW-1:0]      rd_mask_ff;
   logic [MODE_W-1:0]  rd_mode_ff;
   logic               rd_mask_vld_ff, rd_mode_vld_ff;
   logic [SLOT_W-1:0]  rd_idx_ff;
   logic [SW-1:0]      rd_mask;
   logic [MODE_W-1:0]  rd_mode;

   logic [SW-1:0]      acc_ff;
   logic               hit_ff;
   logic [SLOT_W-1:0]  hit_idx_ff;
   logic [MODE_W-1:0]  hit_mode_ff;
   logic [SW-1:0]      last_ff;

   logic [IDX_W:0]     count_raw;
   logic               in_range;
   logic [SLOT_W-1:0]  wr_slot;
   logic               wr_mask_en, wr_mode_en;
   logic [SLOT_W-1:0]  wr_mode_addr;

   assign count_raw  = {1'b0, max_lamp_ff} + (IDX_W+1)'(1);
   assign slot_count = (8'(count_raw) > 8'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS)
                                                       : CNT_W'(count_raw);

   assign flash_lit   = flash_ph_ff   < PHASE_W'(flash_on_ff);
   assign flutter_lit = flutter_ph_ff < PHASE_W'(flutter_on_ff);
   assign wink_lit    = wink_ph_ff    < PHASE_W'(wink_on_ff);

   assign rd_mask = rd_mask_vld_ff ? rd_mask_ff : '0;
   assign rd_mode = rd_mode_vld_ff ? rd_mode_ff : MODE_OFF;

   assign in_range     = 8'(idx_ff) < 8'(slot_count);
   assign wr_slot      = SLOT_W'(idx_ff);
   assign wr_mask_en   = ctl.commit && (cmd_ff == CMD_WRITE_SLOT) && in_range;
   assign wr_mode_en   = wr_mask_en || (ctl.commit && (cmd_ff == CMD_SET_MODE) && hit_ff);
   assign wr_mode_addr = (cmd_ff == CMD_WRITE_SLOT) ? wr_slot : hit_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_lamp_ff    <= MAX_LAMP_INDEX_RST;
         flash_on_ff    <= FLASH_ON_TICKS_RST;
         flash_off_ff   <= FLASH_OFF_TICKS_RST;
         flutter_on_ff  <= FLUTTER_ON_TICKS_RST;
         flutter_off_ff <= FLUTTER_OFF_TICKS_RST;
         wink_on_ff     <= WINK_ON_TICKS_RST;
         wink_off_ff    <= WINK_OFF_TICKS_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MAX_LAMP_INDEX:    max_lamp_ff    <= csr_data[IDX_W-1:0];
            REG_FLASH_ON_TICKS:    flash_on_ff    <= csr_data;
            REG_FLASH_OFF_TICKS:   flash_off_ff   <= csr_data;
            REG_FLUTTER_ON_TICKS:  flutter_on_ff  <= csr_data;
            REG_FLUTTER_OFF_TICKS: flutter_off_ff <= csr_data;
            REG_WINK_ON_TICKS:     wink_on_ff     <= csr_data;
            REG_WINK_OFF_TICKS:    wink_off_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flash_ph_ff   <= '0;
         flutter_ph_ff <= '0;
         wink_ph_ff    <= '0;
      end else if (ctl.phase_step) begin
         flash_ph_ff   <= next_phase(flash_ph_ff, flash_on_ff, flash_off_ff);
         flutter_ph_ff <= next_phase(flutter_ph_ff, flutter_on_ff, flutter_off_ff);
         wink_ph_ff    <= next_phase(wink_ph_ff, wink_on_ff, wink_off_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff  <= req_command;
         idx_ff  <= req_slot_index;
         mask_ff <= req_lamp_mask[SW-1:0];
         mode_ff <= req_lamp_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_mask_en) begin
         mask_mem[wr_slot] <= mask_ff;
      end
      rd_mask_ff <= mask_mem[scan_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_mode_en) begin
         mode_mem[wr_mode_addr] <= mode_ff;
      end
      rd_mode_ff <= mode_mem[scan_addr];
   end

   always_ff @(posedge clock) begin
      rd_idx_ff      <= scan_addr;
      rd_mask_vld_ff <= mask_vld_ff[scan_addr];
      rd_mode_vld_ff <= mode_vld_ff[scan_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_vld_ff <= '0;
         mode_vld_ff <= '0;
      end else begin
         if (wr_mask_en) begin
            mask_vld_ff[wr_slot] <= 1'b1;
         end
         if (wr_mode_en) begin
            mode_vld_ff[wr_mode_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         hit_ff <= 1'b0;
      end else if (ctl.capture) begin
         acc_ff <= '0;
         hit_ff <= 1'b0;
      end else if (ctl.scan_take) begin
         if (cmd_ff == CMD_TICK) begin
            if (mode_lit(rd_mode, flash_lit, flutter_lit, wink_lit)) begin
               acc_ff <= acc_ff | rd_mask;
            end
         end else if (!hit_ff && (rd_mask == mask_ff)) begin
            hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.scan_take && !hit_ff && (rd_mask == mask_ff)) begin
         hit_idx_ff  <= rd_idx_ff;
         hit_mode_ff <= rd_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else if (ctl.commit && (cmd_ff == CMD_TICK)) begin
         last_ff <= acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         unique case (cmd_ff)
            CMD_TICK: begin
               rsp_lamps_on      <= LAMP_W'(acc_ff);
               rsp_lamps_changed <= (acc_ff != last_ff);
               rsp_status        <= 1'b0;
               rsp_mode_read     <= MODE_OFF;
            end
            CMD_WRITE_SLOT: begin
               rsp_lamps_on      <= LAMP_W'(last_ff);
               rsp_lamps_changed <= 1'b0;
               rsp_status        <= !in_range;
               rsp_mode_read     <= MODE_OFF;
            end
            CMD_SET_MODE: begin
               rsp_lamps_on      <= LAMP_W'(last_ff);
               rsp_lamps_changed <= 1'b0;
               rsp_status        <= !hit_ff;
               rsp_mode_read     <= MODE_OFF;
            end
            CMD_READ_MODE: begin
               rsp_lamps_on      <= LAMP_W'(last_ff);
               rsp_lamps_changed <= 1'b0;
               rsp_status        <= !hit_ff;
               rsp_mode_read     <= hit_ff ? hit_mode_ff : MODE_OFF;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> design/lamp_blink_mode_controller.sv
// Top level of the lamp blink mode controller.
`default_nettype none

// The controller keeps a table of lamp slots, each a lamp bit mask and a blink mode, and
// answers every request with exactly one response. A tick request advances the flash,
// flutter and wink phases and returns the OR of the masks of the lit slots; the other
// requests write a slot, set a mode by mask or read a mode by mask. Requests are handled
// one at a time. The slot table has one write and one read port and is scanned one slot
// per cycle, so a tick holds the request channel for a phase step, a scan of the slots
// in use and a commit, a mode set or read for a scan and a commit, a write for a commit.
// The response sits in an output register, so the next request is taken while it waits.
// Register writes are always ready and must only be made while no request is in hand.
module lamp_blink_mode_controller #(
   parameter int NUM_SLOTS = lbm_pkg::NUM_SLOTS_DEF,
   parameter int MASK_BITS = lbm_pkg::MASK_BITS_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   lbm_req_if.sink        req_bus,
   lbm_rsp_if.source      rsp_bus,
   lbm_csr_if.sink        csr_bus
);
   import lbm_pkg::*;

   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   ctl_type            ctl;
   logic [SLOT_W-1:0]  scan_addr;
   logic [CNT_W-1:0]   slot_count;

   assign csr_bus.ready = 1'b1;

   lbm_ctrl #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_ready   (req_bus.ready),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .slot_count  (slot_count),
      .ctl         (ctl),
      .scan_addr   (scan_addr)
   );

   lbm_datapath #(
      .NUM_SLOTS (NUM_SLOTS),
      .MASK_BITS (MASK_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .scan_addr         (scan_addr),
      .slot_count        (slot_count),
      .req_command       (req_bus.command),
      .req_slot_index    (req_bus.slot_index),
      .req_lamp_mask     (req_bus.lamp_mask),
      .req_lamp_mode     (req_bus.lamp_mode),
      .csr_write         (csr_bus.valid),
      .csr_index         (csr_bus.index),
      .csr_data          (csr_bus.data),
      .rsp_lamps_on      (rsp_bus.lamps_on),
      .rsp_lamps_changed (rsp_bus.lamps_changed),
      .rsp_status        (rsp_bus.status),
      .rsp_mode_read     (rsp_bus.mode_read)
   );

endmodule

`default_nettype wire

>>> design/lbm_checker.sv
// Port-level assertions of the lamp blink mode controller and their bind.
`default_nettype none

module lbm_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [lbm_pkg::LAMP_W-1:0]   lamps_on,
   input wire logic                         lamps_changed,
   input wire logic                         status,
   input wire logic [lbm_pkg::MODE_W-1:0]   mode_read
);
   import lbm_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(lamps_on) && $stable(lamps_changed)
                                  && $stable(status) && $stable(mode_read))
      else $error("stalled response changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is in hand");

   a_change_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && lamps_changed |-> !status && (mode_read == MODE_OFF))
      else $error("lamp change flagged on a response that is not a tick");

   a_mode_means_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (mode_read != MODE_OFF) |-> !status)
      else $error("mode returned with not found status");

endmodule

bind lamp_blink_mode_controller lbm_checker u_lbm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .lamps_on      (rsp_bus.lamps_on),
   .lamps_changed (rsp_bus.lamps_changed),
   .status        (rsp_bus.status),
   .mode_read     (rsp_bus.mode_read)
);

`default_nettype wire
